>>> sv/record_rw_lock_table_assert.svh
// assertion macros for the record read/write lock table
// used by rrlt_ctrl and rrlt_datapath; no other dependencies
`ifndef RECORD_RW_LOCK_TABLE_ASSERT_SVH
`define RECORD_RW_LOCK_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define RRLT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rrlt assertion failed");

// consequent must hold in the cycle after the antecedent
`define RRLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrlt assertion failed");

`else

`define RRLT_ASSERT(lbl, clk, rst_n, prop)
`define RRLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/rrlt_pkg.sv
// shared constants, codes and command type of the record read/write lock table
// no dependencies
package rrlt_pkg;

  localparam int LOCK_SLOTS  = 16;
  localparam int READER_BITS = 8;
  localparam int SLOT_W      = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;

  localparam int OP_W       = 2;
  localparam int KEY_W      = 31;
  localparam int ST_W       = 3;
  localparam int MODE_W     = 2;
  localparam int RD_OUT_W   = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USED_W = ST_W + MODE_W + RD_OUT_W;

  // opcodes
  localparam logic [OP_W-1:0] OP_READ   = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_UNLOCK = 2'd2;

  // lock modes
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  // result status
  localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
  localparam logic [ST_W-1:0] ST_CONFLICT = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_LIMIT    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_HELD = 3'd4;

  localparam logic [READER_BITS-1:0] READER_MAX = {READER_BITS{1'b1}};
  localparam logic [READER_BITS-1:0] READER_ONE = READER_BITS'(1);

  // controller to datapath commands
  typedef struct packed {
    logic load_req;  // capture the incoming request
    logic exec;      // update the table and load the result register
  } rrlt_cmd_t;

endpackage

>>> sv/record_rw_lock_table.sv
// top level of the record read/write lock table
// depends on rrlt_pkg, rrlt_ctrl and rrlt_datapath
//
// usage
//   in channel: one lock request per transaction; in_tdata holds opcode
//     (read lock, write lock, unlock) and the 31-bit record key
//   out channel: one result per request, in request order; out_tdata holds
//     status, the key's mode afterwards and its reader count afterwards
//   the table holds LOCK_SLOTS keys, matched against the request in parallel
// timing
//   an accepted request is captured, then executed in S_EXEC once the result
//   register is free or draining, a read-modify-write of the matched or lowest
//   free slot; out_tvalid is set on the edge that ends that execute cycle
//   a new request is taken only once the previous one has executed (capture
//   then table update), set by the single shared compare and update unit
//   in_tready is high in the capture cycle even while a result still waits
// reset
//   synchronous active-low rst_n frees every slot and drops any pending result
// stall
//   while out_tready is low a finished result holds in the output register;
//   one more request may be accepted and waits until the register drains
module record_rw_lock_table
  import rrlt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [1:0] opcode, [32:2] record_key
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [2:0] status, [4:3] mode_after,
                                            // [12:5] readers_after
);

  // commands from the state machine to the slot table
  rrlt_cmd_t cmd;

  // handshake sequencing and result valid flag
  rrlt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // slot table, key match, lock update and result register
  rrlt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

>>> sv/rrlt_ctrl.sv
// control state machine of the record read/write lock table
// depends on rrlt_pkg and record_rw_lock_table_assert.svh
`include "record_rw_lock_table_assert.svh"

module rrlt_ctrl
  import rrlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output rrlt_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = out_valid_r;
  assign cmd.load_req = in_tvalid && in_tready;
  // result register free, or being emptied this cycle
  assign cmd.exec     = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load_req) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RRLT_ASSERT(a_exec_slot_free, clk, rst_n, !cmd.exec || !out_valid_r || out_tready)
  `RRLT_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, cmd.load_req, state_r == S_EXEC)
  `RRLT_ASSERT_NEXT(a_exec_gives_result, clk, rst_n, cmd.exec, out_valid_r && state_r == S_IDLE)

endmodule

>>> sv/rrlt_datapath.sv
// lock slot table, parallel key match and result register
// depends on rrlt_pkg and record_rw_lock_table_assert.svh
`include "record_rw_lock_table_assert.svh"

module rrlt_datapath
  import rrlt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  rrlt_cmd_t             cmd,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // captured request
  logic [OP_W-1:0]  req_op_r;
  logic [KEY_W-1:0] req_key_r;

  // slot table
  logic [KEY_W-1:0]       key_r  [LOCK_SLOTS];
  logic [MODE_W-1:0]      mode_r [LOCK_SLOTS];
  logic [READER_BITS-1:0] rd_r   [LOCK_SLOTS];

  // result register
  logic [ST_W-1:0]     res_st_r;
  logic [MODE_W-1:0]   res_mode_r;
  logic [RD_OUT_W-1:0] res_rd_r;

  logic [LOCK_SLOTS-1:0]  hit_vec, free_vec;
  logic [SLOT_W-1:0]      hit_idx, free_idx;
  logic                   hit_any, free_any;
  logic [MODE_W-1:0]      cur_mode;
  logic [READER_BITS-1:0] cur_rd;

  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_idx;
  logic [KEY_W-1:0]       wr_key;
  logic [MODE_W-1:0]      wr_mode;
  logic [READER_BITS-1:0] wr_rd;
  logic [ST_W-1:0]        res_st;
  logic [MODE_W-1:0]      res_mode;
  logic [READER_BITS-1:0] res_rd;

  always_comb begin
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      hit_vec[i]  = (mode_r[i] != MODE_NONE) && (key_r[i] == req_key_r);
      free_vec[i] = (mode_r[i] == MODE_NONE);
    end
  end

  // lowest index wins
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = LOCK_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = |free_vec;
  assign cur_mode = mode_r[hit_idx];
  assign cur_rd   = rd_r[hit_idx];

  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = hit_idx;
    wr_key   = key_r[hit_idx];
    wr_mode  = cur_mode;
    wr_rd    = cur_rd;
    res_st   = ST_NOT_HELD;
    res_mode = MODE_NONE;
    res_rd   = '0;
    case (req_op_r)
      OP_READ, OP_WRITE: begin
        if (hit_any) begin
          if (req_op_r == OP_WRITE || cur_mode == MODE_WRITE) begin
            res_st   = ST_CONFLICT;
            res_mode = cur_mode;
            res_rd   = cur_rd;
          end else if (cur_rd == READER_MAX) begin
            res_st   = ST_LIMIT;
            res_mode = cur_mode;
            res_rd   = cur_rd;
          end else begin
            wr_en    = 1'b1;
            wr_mode  = MODE_READ;
            wr_rd    = cur_rd + READER_ONE;
            res_st   = ST_DONE;
            res_mode = MODE_READ;
            res_rd   = cur_rd + READER_ONE;
          end
        end else if (!free_any) begin
          res_st = ST_FULL;
        end else begin
          wr_en  = 1'b1;
          wr_idx = free_idx;
          wr_key = req_key_r;
          res_st = ST_DONE;
          if (req_op_r == OP_READ) begin
            wr_mode  = MODE_READ;
            wr_rd    = READER_ONE;
            res_mode = MODE_READ;
            res_rd   = READER_ONE;
          end else begin
            wr_mode  = MODE_WRITE;
            wr_rd    = '0;
            res_mode = MODE_WRITE;
          end
        end
      end
      OP_UNLOCK: begin
        if (hit_any) begin
          wr_en  = 1'b1;
          res_st = ST_DONE;
          if (cur_mode == MODE_READ && cur_rd > READER_ONE) begin
            wr_rd    = cur_rd - READER_ONE;
            res_mode = MODE_READ;
            res_rd   = cur_rd - READER_ONE;
          end else begin
            // last holder gone, slot returns to the free pool
            wr_key  = '0;
            wr_mode = MODE_NONE;
            wr_rd   = '0;
          end
        end
      end
      default: begin
        // unused opcode only reports
        if (hit_any) begin
          res_mode = cur_mode;
          res_rd   = cur_rd;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r  <= in_tdata[OP_W-1:0];
      req_key_r <= in_tdata[OP_W+KEY_W-1:OP_W];
    end
    if (cmd.exec) begin
      res_st_r   <= res_st;
      res_mode_r <= res_mode;
      res_rd_r   <= RD_OUT_W'(res_rd);
    end
    if (cmd.exec && wr_en) begin
      key_r[wr_idx] <= wr_key;
      rd_r[wr_idx]  <= wr_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LOCK_SLOTS; i++) begin
        mode_r[i] <= MODE_NONE;
      end
    end else if (cmd.exec && wr_en) begin
      mode_r[wr_idx] <= wr_mode;
    end
  end

  assign out_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), res_rd_r, res_mode_r, res_st_r};

  // keys stay unique among held slots
  `RRLT_ASSERT(a_single_hit, clk, rst_n, $onehot0(hit_vec))
  // a full report only when no slot is free
  `RRLT_ASSERT(a_full_no_free, clk, rst_n, !(cmd.exec && res_st == ST_FULL) || !free_any)

endmodule
